// ===== sv/two_level_bitmap_frame_allocator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Frame allocator assertion macros
// Shared property wrappers for the allocator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_BITMAP_FRAME_ALLOCATOR_UNIT_DEFINES_SVH
`define TWO_LEVEL_BITMAP_FRAME_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define TLBFA_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define TLBFA_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== sv/tlbfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame allocator package
// Item types, operation and status codes, register indexes.
// ----------------------------------------------------------------------------
package tlbfa_pkg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] frame_number;
        logic [31:0] range_start;
        logic [31:0] range_length;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] granted_frame;
        logic [31:0] granted_address;
    } rsp_t;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RESERVE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    localparam logic REG_MEMORY_BASE = 1'b0;
    localparam logic REG_FRAME_LIMIT = 1'b1;

    localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;
    localparam logic [16:0] FRAME_LIMIT_RESET = 17'h1_0000;

endpackage

// ===== sv/tlbfa_ram.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tlbfa_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/tlbfa_fzb.sv =====
// ----------------------------------------------------------------------------
// First zero bit finder
// Lowest clear bit of a 32-bit word.
// ----------------------------------------------------------------------------
module tlbfa_fzb (
    input  logic [31:0] word,
    output logic        found,
    output logic [4:0]  idx
);

    always_comb
    begin
        found = 1'b0;
        idx   = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!word[i])
            begin
                found = 1'b1;
                idx   = 5'(i);
            end
        end
    end

endmodule

// ===== sv/tlbfa_div.sv =====
// ----------------------------------------------------------------------------
// Map index unit
// Quotient by a power-of-two divisor as a right shift, ready in the cycle after
// start.
// ----------------------------------------------------------------------------
module tlbfa_div #(
    parameter int DIVISOR = 32,
    parameter int DW      = 11,
    parameter int QW      = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    output logic          done,
    output logic [QW-1:0] quotient
);

    // DIVISOR is a power of two
    localparam int SH = $clog2(DIVISOR);

    logic          done_reg;
    logic [QW-1:0] q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            q_reg    <= '0;
        end
        else
        begin
            done_reg <= start;
            if (start)
            begin
                q_reg <= QW'(dividend >> SH);
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== sv/two_level_bitmap_frame_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Two-level bitmap frame allocator
// Frame bitmap in a synchronous memory, map summary bits in flops; allocate,
// free and reserve-range operations, one item at a time.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  req      | req_valid / req_stall | opcode, frame_number, range_start/length
//  rsp      | rsp_valid / rsp_stall | status, granted_frame, granted_address
//  cfg      | cfg_valid / cfg_ready | cfg_index (0 base, 1 limit), cfg_data
//
//  Allocate: a summary word scan, then the chosen map read one word per cycle.
//  Free: a read, a registered map index and a write back.
//  Reserve: range checks, map indexes, then a read and write back of each word
//  of the touched maps; a rejected item stops after the range checks.
//  After reset the bitmap is cleared, one word a cycle; req_stall is high meanwhile.
//  A finished item waits in the output register; a new item is taken meanwhile.
// ----------------------------------------------------------------------------
`include "two_level_bitmap_frame_allocator_unit_defines.svh"

module two_level_bitmap_frame_allocator_unit #(
    parameter int FRAMES_PER_MAP = 1024,
    parameter int NUM_MAPS       = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  tlbfa_pkg::req_t  req_data,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output tlbfa_pkg::rsp_t  rsp_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [31:0]      cfg_data
);

    import tlbfa_pkg::*;

    // Geometry
    localparam int WPM          = FRAMES_PER_MAP / 32;
    localparam int TOTAL_WORDS  = NUM_MAPS * WPM;
    localparam int TOTAL_FRAMES = NUM_MAPS * FRAMES_PER_MAP;
    localparam int AW           = $clog2(TOTAL_WORDS);
    localparam int FW           = AW + 5;
    localparam int MAP_W        = $clog2(NUM_MAPS);
    localparam int SUM_WORDS    = (NUM_MAPS + 31) / 32;
    localparam int SUM_PAD      = SUM_WORDS * 32;
    localparam int SCW          = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
    localparam int CW           = (WPM > 1) ? $clog2(WPM) : 1;
    // Padding summary bits beyond the last map read as full.
    localparam logic [SUM_PAD-1:0] SUM_INIT = {SUM_PAD{1'b1}} << NUM_MAPS;

    // Sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] A_SUM   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] A_WR    = 4'd6;
    localparam logic [3:0] F_WAIT  = 4'd7;
    localparam logic [3:0] R_CHK1  = 4'd8;
    localparam logic [3:0] R_CHK2  = 4'd9;
    localparam logic [3:0] R_DIV1  = 4'd10;
    localparam logic [3:0] R_DIV2  = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0]         state_reg;
    req_t               req_reg;
    rsp_t               res_reg;
    rsp_t               rsp_reg;
    logic               rsp_valid_reg;
    logic [31:0]        base_reg;
    logic [16:0]        limit_reg;
    logic [SUM_PAD-1:0] sum_reg;
    logic [AW-1:0]      clr_reg;
    logic [SCW-1:0]     sc_reg;
    logic [MAP_W-1:0]   map_reg;
    logic [MAP_W-1:0]   mlast_reg;
    logic [AW-1:0]      a_reg;
    logic [AW-1:0]      aend_reg;
    logic [CW-1:0]      c_reg;
    logic [MAP_W-1:0]   m_reg;
    logic               iss_done_reg;
    logic               pend_valid_reg;
    logic [AW-1:0]      pend_addr_reg;
    logic               pend_last_reg;
    logic [MAP_W-1:0]   pend_map_reg;
    logic               acc_reg;
    logic               found_reg;
    logic               other_reg;
    logic [AW-1:0]      faddr_reg;
    logic [31:0]        fword_reg;
    logic               rej_reg;
    logic [19:0]        f20_reg;
    logic [19:0]        l20_reg;
    logic [FW-1:0]      f_reg;
    logic [FW-1:0]      l_reg;

    // Memory ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    // Divider
    logic             div_start;
    logic [AW-1:0]    div_dividend;
    logic             div_done;
    logic [MAP_W-1:0] div_quot;

    // Finders
    logic [MAP_W-1:0] sum_base;
    logic [31:0]      sum_word;
    logic             sum_found;
    logic [4:0]       sum_idx;
    logic             fw_found;
    logic [4:0]       fw_idx;

    // Decode helpers
    logic          free_in_range;
    logic [AW-1:0] free_word;
    logic [31:0]   free_bit;
    logic          rsv_reject;
    logic [32:0]   rsv_end;
    logic [AW-1:0] fw_addr;
    logic [AW-1:0] lw_addr;
    logic          in_span;
    logic [4:0]    mask_lo;
    logic [4:0]    mask_hi;
    logic [31:0]   rsv_mask;
    logic [31:0]   rsv_word;
    logic          full_now;
    logic [31:0]   grant_word;
    logic [FW-1:0] grant_frame;

    tlbfa_ram #(
        .DEPTH (TOTAL_WORDS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tlbfa_div #(
        .DIVISOR (WPM),
        .DW      (AW),
        .QW      (MAP_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quot)
    );

    // First non-full map within the current summary word
    assign sum_base = MAP_W'({sc_reg, 5'd0});
    assign sum_word = sum_reg[sum_base +: 32];

    tlbfa_fzb u_sum_fzb (
        .word  (sum_word),
        .found (sum_found),
        .idx   (sum_idx)
    );

    // First free frame within the chosen word
    tlbfa_fzb u_word_fzb (
        .word  (fword_reg),
        .found (fw_found),
        .idx   (fw_idx)
    );

    assign grant_word  = fword_reg | (32'd1 << fw_idx);
    assign grant_frame = {faddr_reg, fw_idx};

    assign free_in_range = 32'(req_reg.frame_number) < 32'(TOTAL_FRAMES);
    assign free_word     = AW'(req_reg.frame_number >> 5);
    assign free_bit      = 32'd1 << req_reg.frame_number[4:0];

    assign rsv_end    = 33'(req_reg.range_start) + 33'(req_reg.range_length);
    assign rsv_reject = rej_reg
                        || (21'(l20_reg) >= 21'(limit_reg))
                        || (32'(l20_reg) >= 32'(TOTAL_FRAMES));

    // Reserve mask for the word coming back from memory
    assign fw_addr  = f_reg[FW-1:5];
    assign lw_addr  = l_reg[FW-1:5];
    assign in_span  = (pend_addr_reg >= fw_addr) && (pend_addr_reg <= lw_addr);
    assign mask_lo  = (pend_addr_reg == fw_addr) ? f_reg[4:0] : 5'd0;
    assign mask_hi  = (pend_addr_reg == lw_addr) ? l_reg[4:0] : 5'd31;
    assign rsv_mask = in_span ? ((WORD_ONES << mask_lo) & (WORD_ONES >> (5'd31 - mask_hi)))
                              : 32'd0;
    assign rsv_word = ram_rdata | rsv_mask;
    assign full_now = acc_reg && (rsv_word == WORD_ONES);

    // Divider operand and launch
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = AW'(req_reg.frame_number >> 5);
        unique case (state_reg)
            S_DEC:
            begin
                div_start = (req_reg.opcode == OP_FREE) && free_in_range;
            end
            R_CHK2:
            begin
                div_start    = !rsv_reject;
                div_dividend = AW'(f20_reg >> 5);
            end
            R_DIV1:
            begin
                div_start    = div_done;
                div_dividend = AW'(l20_reg >> 5);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Memory port steering
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = 32'd0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
            end
            S_DEC:
            begin
                ram_re    = (req_reg.opcode == OP_FREE) && free_in_range;
                ram_raddr = free_word;
            end
            S_SCAN:
            begin
                ram_re    = !iss_done_reg;
                ram_raddr = a_reg;
                ram_we    = pend_valid_reg && (req_reg.opcode == OP_RESERVE);
                ram_waddr = pend_addr_reg;
                ram_wdata = rsv_word;
            end
            A_WR:
            begin
                ram_we    = found_reg;
                ram_waddr = faddr_reg;
                ram_wdata = grant_word;
            end
            F_WAIT:
            begin
                ram_we    = div_done;
                ram_waddr = free_word;
                ram_wdata = ram_rdata & ~free_bit;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            req_reg        <= '0;
            res_reg        <= '0;
            rsp_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            base_reg       <= 32'd0;
            limit_reg      <= FRAME_LIMIT_RESET;
            sum_reg        <= SUM_INIT;
            clr_reg        <= '0;
            sc_reg         <= '0;
            map_reg        <= '0;
            mlast_reg      <= '0;
            a_reg          <= '0;
            aend_reg       <= '0;
            c_reg          <= '0;
            m_reg          <= '0;
            iss_done_reg   <= 1'b1;
            pend_valid_reg <= 1'b0;
            pend_addr_reg  <= '0;
            pend_last_reg  <= 1'b0;
            pend_map_reg   <= '0;
            acc_reg        <= 1'b1;
            found_reg      <= 1'b0;
            other_reg      <= 1'b0;
            faddr_reg      <= '0;
            fword_reg      <= 32'd0;
            rej_reg        <= 1'b0;
            f20_reg        <= '0;
            l20_reg        <= '0;
            f_reg          <= '0;
            l_reg          <= '0;
        end
        else
        begin
            // Register writes; taken in any state
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_MEMORY_BASE: base_reg  <= cfg_data;
                    REG_FRAME_LIMIT: limit_reg <= cfg_data[16:0];
                endcase
            end

            // Drop the result once the consumer takes it; a new result
            // loaded in the same cycle is handled by S_DONE
            if (rsp_valid_reg && !rsp_stall && (state_reg != S_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(TOTAL_WORDS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg   <= req_data;
                        state_reg <= S_DEC;
                    end
                end

                S_DEC:
                begin
                    res_reg <= '{status: ST_OK, granted_frame: 16'd0, granted_address: 32'd0};
                    unique case (req_reg.opcode)
                        OP_ALLOC:
                        begin
                            sc_reg    <= '0;
                            state_reg <= A_SUM;
                        end
                        OP_FREE:
                        begin
                            state_reg <= free_in_range ? F_WAIT : S_DONE;
                        end
                        OP_RESERVE:
                        begin
                            state_reg <= R_CHK1;
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end

                A_SUM:
                begin
                    if (sum_found)
                    begin
                        map_reg   <= MAP_W'({sc_reg, sum_idx});
                        mlast_reg <= MAP_W'({sc_reg, sum_idx});
                        state_reg <= S_MUL;
                    end
                    else if (sc_reg == SCW'(SUM_WORDS - 1))
                    begin
                        res_reg.status <= ST_FULL;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        sc_reg <= sc_reg + 1'b1;
                    end
                end

                S_MUL:
                begin
                    a_reg          <= AW'(32'(map_reg) * WPM);
                    aend_reg       <= AW'(32'(mlast_reg) * WPM + WPM - 1);
                    m_reg          <= map_reg;
                    c_reg          <= '0;
                    iss_done_reg   <= 1'b0;
                    pend_valid_reg <= 1'b0;
                    acc_reg        <= 1'b1;
                    found_reg      <= 1'b0;
                    other_reg      <= 1'b0;
                    state_reg      <= S_SCAN;
                end

                S_SCAN:
                begin
                    // Issue side: one word read per cycle
                    pend_valid_reg <= !iss_done_reg;
                    if (!iss_done_reg)
                    begin
                        pend_addr_reg <= a_reg;
                        pend_last_reg <= (c_reg == CW'(WPM - 1));
                        pend_map_reg  <= m_reg;
                        if (a_reg == aend_reg)
                        begin
                            iss_done_reg <= 1'b1;
                        end
                        else
                        begin
                            a_reg <= a_reg + 1'b1;
                        end
                        if (c_reg == CW'(WPM - 1))
                        begin
                            c_reg <= '0;
                            m_reg <= m_reg + 1'b1;
                        end
                        else
                        begin
                            c_reg <= c_reg + 1'b1;
                        end
                    end

                    // Return side: inspect the word read last cycle
                    if (pend_valid_reg)
                    begin
                        if (req_reg.opcode == OP_ALLOC)
                        begin
                            if (ram_rdata != WORD_ONES)
                            begin
                                if (!found_reg)
                                begin
                                    found_reg <= 1'b1;
                                    faddr_reg <= pend_addr_reg;
                                    fword_reg <= ram_rdata;
                                end
                                else
                                begin
                                    other_reg <= 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            if (pend_last_reg)
                            begin
                                if (full_now)
                                begin
                                    sum_reg[pend_map_reg] <= 1'b1;
                                end
                                acc_reg <= 1'b1;
                            end
                            else
                            begin
                                acc_reg <= full_now;
                            end
                        end
                    end

                    if (iss_done_reg && !pend_valid_reg)
                    begin
                        state_reg <= (req_reg.opcode == OP_ALLOC) ? A_WR : S_DONE;
                    end
                end

                A_WR:
                begin
                    if (found_reg && fw_found)
                    begin
                        if (!other_reg && (grant_word == WORD_ONES))
                        begin
                            sum_reg[map_reg] <= 1'b1;
                        end
                        res_reg.granted_frame   <= 16'(grant_frame);
                        res_reg.granted_address <= base_reg + (32'(grant_frame) << 12);
                    end
                    else
                    begin
                        res_reg.status <= ST_FULL;
                    end
                    state_reg <= S_DONE;
                end

                F_WAIT:
                begin
                    if (div_done)
                    begin
                        sum_reg[div_quot] <= 1'b0;
                        state_reg         <= S_DONE;
                    end
                end

                R_CHK1:
                begin
                    rej_reg   <= (req_reg.range_start < base_reg) || rsv_end[32];
                    f20_reg   <= 20'((req_reg.range_start - base_reg) >> 12);
                    l20_reg   <= 20'((rsv_end[31:0] - base_reg) >> 12);
                    state_reg <= R_CHK2;
                end

                R_CHK2:
                begin
                    if (rsv_reject)
                    begin
                        res_reg.status <= ST_REJECT;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        f_reg     <= FW'(f20_reg);
                        l_reg     <= FW'(l20_reg);
                        state_reg <= R_DIV1;
                    end
                end

                R_DIV1:
                begin
                    if (div_done)
                    begin
                        map_reg   <= div_quot;
                        state_reg <= R_DIV2;
                    end
                end

                R_DIV2:
                begin
                    if (div_done)
                    begin
                        mlast_reg <= div_quot;
                        state_reg <= S_MUL;
                    end
                end

                S_DONE:
                begin
                    // Advance only when the output register is free
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_reg       <= res_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign cfg_ready = 1'b1;

    // A pending read never runs past the last word of the scan
    `TLBFA_ASSERT_NOW(a_scan_bound, (state_reg == S_SCAN) && pend_valid_reg, pend_addr_reg <= aend_reg, "scan read beyond end")
    // No read response is left over once the block is idle
    `TLBFA_ASSERT_NOW(a_idle_drained, state_reg == S_IDLE, !pend_valid_reg && iss_done_reg, "scan not drained")
    // Only a reserve item can be rejected
    `TLBFA_ASSERT_NOW(a_reject_src, (state_reg == S_DONE) && (res_reg.status == ST_REJECT), req_reg.opcode == OP_RESERVE, "reject from non-reserve item")
    // A finished item leaves the sequencer ready for the next one
    `TLBFA_ASSERT_NEXT(a_done_idle, (state_reg == S_DONE) && !rsp_valid_reg, state_reg == S_IDLE, "result not loaded")

endmodule

// ===== sim/tb_two_level_bitmap_frame_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Frame allocator testbench
// Drives allocate, free, reserve and unused-opcode items into the allocator
// under random idling and one long output hold-off, takes each expected result
// from a typed row or a local bitmap copy, and compares field by field in order.
// ----------------------------------------------------------------------------
module tb_two_level_bitmap_frame_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tlbfa_pkg::*;

    localparam int          MAP_FRAMES  = 1024;
    localparam int          MAP_COUNT   = 64;
    localparam int          MAP_WORDS   = MAP_FRAMES / 32;
    localparam int          FRAME_COUNT = MAP_FRAMES * MAP_COUNT;
    localparam int          WORD_COUNT  = FRAME_COUNT / 32;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam int          SETTLE      = 80;   // cycles after the last result

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req_data  = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = REG_MEMORY_BASE;
    logic [31:0] cfg_data  = '0;

    two_level_bitmap_frame_allocator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Local copy of the allocator state: frame bitmap, map summary, registers.
    bit [31:0]         used_words [WORD_COUNT];
    bit [MAP_COUNT-1:0] full_maps;
    bit [31:0]         base_addr;
    bit [16:0]         limit_frame;

    rsp_t        pending_results [$];
    int unsigned granted_frames  [$];   // frames handed out, candidates to free
    int          errors;
    int          n_granted, n_full, n_rejected, n_items;
    bit          no_idle;
    bit          hold_arm;
    logic        hold_off = 1'b0;
    int          rsp_gap;

    // Directed rows: typed expectation where it is obvious, else predicted.
    typedef struct {
        req_t req;
        bit   typed;
        rsp_t res;
    } row_t;

    function automatic bit map_full(int unsigned m);
        for (int w = 0; w < MAP_WORDS; w++)
        begin
            if (used_words[m * MAP_WORDS + w] != WORD_ONES)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Apply one item to the local state and return the result it yields.
    function automatic rsp_t allocator_outcome(req_t r);
        rsp_t        res;
        int          m;
        int          wi;
        int unsigned frame;
        bit [32:0]   stop;
        bit [32:0]   lo;
        bit [32:0]   hi;
        bit [31:0]   word;

        res = '0;
        m   = -1;
        case (r.opcode)
            OP_ALLOC:
            begin
                res.status = ST_FULL;
                for (int i = 0; i < MAP_COUNT && m < 0; i++)
                    if (!full_maps[i])
                        m = i;
                if (m >= 0)
                begin
                    for (int w = 0; w < MAP_WORDS; w++)
                    begin
                        wi   = m * MAP_WORDS + w;
                        word = used_words[wi];
                        if (word != WORD_ONES)
                        begin
                            frame = wi * 32;
                            for (int b = 31; b >= 0; b--)
                                if (!word[b])
                                    frame = wi * 32 + b;
                            used_words[frame / 32][frame % 32] = 1'b1;
                            if (map_full(m))
                                full_maps[m] = 1'b1;
                            res.status          = ST_OK;
                            res.granted_frame   = frame[15:0];
                            res.granted_address = base_addr + (frame << 12);
                            break;
                        end
                    end
                end
            end
            OP_FREE:
            begin
                frame = r.frame_number;
                used_words[frame / 32][frame % 32] = 1'b0;
                full_maps[frame / MAP_FRAMES]      = 1'b0;
            end
            OP_RESERVE:
            begin
                stop = {1'b0, r.range_start} + {1'b0, r.range_length};
                if (r.range_start < base_addr || stop > {1'b0, WORD_ONES})
                    res.status = ST_REJECT;
                else
                begin
                    lo = ({1'b0, r.range_start} - base_addr) >> 12;
                    hi = (stop - base_addr) >> 12;
                    if (hi >= limit_frame || hi >= FRAME_COUNT)
                        res.status = ST_REJECT;
                    else
                    begin
                        for (int unsigned f = 32'(lo); f <= 32'(hi); f++)
                            used_words[f / 32][f % 32] = 1'b1;
                        for (int unsigned k = 32'(lo) / MAP_FRAMES;
                             k <= 32'(hi) / MAP_FRAMES; k++)
                            if (map_full(k))
                                full_maps[k] = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // Compare one accepted result with the oldest expectation.
    task automatic check_result(rsp_t got);
        rsp_t want;
        if (pending_results.size() == 0)
        begin
            report("unexpected item, frame", 32'(got.granted_frame), 32'd0);
            return;
        end
        want = pending_results.pop_front();
        if (got.status != want.status)
            report("status", 32'(got.status), 32'(want.status));
        if (got.granted_frame != want.granted_frame)
            report("granted_frame", 32'(got.granted_frame), 32'(want.granted_frame));
        if (got.granted_address != want.granted_address)
            report("granted_address", got.granted_address, want.granted_address);
    endtask

    // Receiver: draw a stall for each item, hold completely during hold_off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_gap = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                check_result(rsp_data);
                rsp_gap = no_idle ? 0 : $urandom_range(0, 3);
            end
            else if (rsp_gap > 0)
                rsp_gap--;
            rsp_stall <= hold_off || (rsp_gap != 0);
        end
    end

    // Long hold-off on the result side: the sender keeps offering items,
    // so the block fills its output register and pushes back on req_stall.
    initial
    begin
        wait (hold_arm);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Offer one item after a random gap, wait for acceptance, record result.
    task automatic send_item(req_t r, bit typed = 1'b0, rsp_t typed_res = '0);
        int   gap;
        rsp_t res;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        res = allocator_outcome(r);
        if (r.opcode == OP_ALLOC && res.status == ST_OK)
            granted_frames.push_back(res.granted_frame);
        n_items++;
        case (res.status)
            ST_FULL:   n_full++;
            ST_REJECT: n_rejected++;
            default:   if (r.opcode == OP_ALLOC) n_granted++;
        endcase
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // Drain results, let the block settle, then write one register.
    task automatic write_reg(logic idx, logic [31:0] value);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_MEMORY_BASE)
            base_addr = value;
        else
            limit_frame = value[16:0];
    endtask

    // Random item: any opcode; frees and reserves are mostly well-formed, near managed memory.
    function automatic req_t random_item();
        req_t        r;
        logic [95:0] raw;
        int          pick;
        int unsigned span;
        int          idx;
        raw = {$urandom, $urandom, $urandom};
        r = raw[$bits(req_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 45)
            r.opcode = OP_ALLOC;
        else if (pick < 72)
        begin
            r.opcode = OP_FREE;
            pick = $urandom_range(0, 9);
            if (pick < 5 && granted_frames.size() > 0)
            begin
                idx = $urandom_range(0, granted_frames.size() - 1);
                r.frame_number = granted_frames[idx];
                granted_frames.delete(idx);
            end
            else if (pick < 8)
                r.frame_number = $urandom_range(0, 4095);
        end
        else if (pick < 95)
        begin
            r.opcode = OP_RESERVE;
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                span = (limit_frame > 65535) ? 65535 : limit_frame + 4;
                r.range_start = base_addr + ($urandom_range(0, span) << 12)
                                + $urandom_range(0, 4095);
                r.range_length = (pick < 65) ? $urandom_range(0, 4 * 4096)
                                             : $urandom_range(0, MAP_FRAMES * 4096);
            end
        end
        else
            r.opcode = OP_UNUSED;
        return r;
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            send_item(random_item());
    endtask

    function automatic req_t make_item(logic [1:0] op, logic [15:0] frame,
                                       logic [31:0] start, logic [31:0] len);
        req_t r;
        r.opcode       = op;
        r.frame_number = frame;
        r.range_start  = start;
        r.range_length = len;
        return r;
    endfunction

    row_t directed [$];

    initial
    begin
        #(200_000_000);
        $display("timeout: results still outstanding");
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        foreach (used_words[i])
            used_words[i] = '0;
        full_maps   = '0;
        base_addr   = '0;
        limit_frame = FRAME_LIMIT_RESET;

        // Directed rows with base 0 and the full frame limit.
        directed.push_back('{make_item(OP_ALLOC, 16'hFFFF, '1, '1), 1, '{ST_OK, 16'd0, 32'h0}});
        directed.push_back('{make_item(OP_ALLOC, 0, 0, 0), 1, '{ST_OK, 16'd1, 32'h1000}});
        directed.push_back('{make_item(OP_FREE, 0, 0, 0), 1, '0});
        directed.push_back('{make_item(OP_ALLOC, 0, 0, 0), 0, '0});
        // free of a frame that is already free
        directed.push_back('{make_item(OP_FREE, 16'hFFFF, 0, 0), 1, '0});
        directed.push_back('{make_item(OP_UNUSED, 16'hFFFF, '1, '1), 1, '0});
        directed.push_back('{make_item(OP_RESERVE, 0, 0, 0), 1, '0});
        // end address past the 32-bit space
        directed.push_back('{make_item(OP_RESERVE, 0, '1, 32'd1), 1, '{ST_REJECT, 16'd0, 32'h0}});
        // end frame beyond capacity
        directed.push_back('{make_item(OP_RESERVE, 0, 0, '1), 1, '{ST_REJECT, 16'd0, 32'h0}});
        // end frame at the frame limit
        directed.push_back('{make_item(OP_RESERVE, 0, 32'h1000_0000, 0), 1,
                             '{ST_REJECT, 16'd0, 32'h0}});
        // reserve all of memory, then memory full
        directed.push_back('{make_item(OP_RESERVE, 0, 0, 32'h0FFF_FFFF), 1, '0});
        directed.push_back('{make_item(OP_ALLOC, 0, 0, 0), 1, '{ST_FULL, 16'd0, 32'h0}});
        directed.push_back('{make_item(OP_FREE, 16'h8000, 0, 0), 1, '0});
        directed.push_back('{make_item(OP_ALLOC, 0, 0, 0), 0, '0});
        directed.push_back('{make_item(OP_ALLOC, 0, 0, 0), 1, '{ST_FULL, 16'd0, 32'h0}});
        directed.push_back('{make_item(OP_FREE, 16'd1023, 0, 0), 1, '0});
        directed.push_back('{make_item(OP_FREE, 16'd0, 0, 0), 1, '0});
        directed.push_back('{make_item(OP_ALLOC, 0, 0, 0), 1, '{ST_OK, 16'd0, 32'h0}});
        directed.push_back('{make_item(OP_ALLOC, 0, 0, 0), 0, '0});
        directed.push_back('{make_item(OP_ALLOC, 0, 0, 0), 1, '{ST_FULL, 16'd0, 32'h0}});
        directed.push_back('{make_item(OP_FREE, 16'hFFFF, 0, 0), 1, '0});
        directed.push_back('{make_item(OP_ALLOC, 0, 0, 0), 0, '0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Phase 0: reset register values, directed table, then random.
        write_reg(REG_MEMORY_BASE, 32'h0);
        write_reg(REG_FRAME_LIMIT, 32'h1_0000);
        foreach (directed[i])
            send_item(directed[i].req, directed[i].typed, directed[i].res);
        hold_arm = 1'b1;
        run_random(500);

        // Phase 1: highest base, zero limit, no idling on either side.
        write_reg(REG_MEMORY_BASE, 32'hFFFF_F000);
        write_reg(REG_FRAME_LIMIT, 32'h0);
        no_idle = 1'b1;
        run_random(250);
        no_idle = 1'b0;

        // Phase 2: odd base, small limit.
        write_reg(REG_MEMORY_BASE, 32'h1234_5000);
        write_reg(REG_FRAME_LIMIT, 32'd300);
        run_random(500);

        // Phase 3: random aligned base, full limit.
        write_reg(REG_MEMORY_BASE, $urandom & 32'hFFFF_F000);
        write_reg(REG_FRAME_LIMIT, 32'h1_0000);
        run_random(500);

        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d items: %0d frames granted, %0d memory-full, %0d ranges rejected",
                 n_items, n_granted, n_full, n_rejected);
        $display("four register settings, including zero limit and top base; %0d mismatches",
                 errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
